### src/cdse_pkg.sv
// Package for the calendar date serial engine.
// Holds the field widths, the action and sequencer state codes, and the month length table.
// No dependencies.
package cdse_pkg;

	localparam int ACTION_W = 3;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int DAYS_W   = 18;
	localparam int SERIAL_W = 17;
	localparam int DIFF_W   = 18;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD_DATE   = 3'd0,
		ACT_LOAD_SERIAL = 3'd1,
		ACT_NEXT_DAY    = 3'd2,
		ACT_PREV_DAY    = 3'd3,
		ACT_ADD_DAYS    = 3'd4,
		ACT_DIFFERENCE  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_YEAR,
		ST_MONTH,
		ST_PUSH
	} state_t;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		unique case (m)
			4'd2:                    month_days = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
			default:                 month_days = 5'd31;
		endcase
	endfunction

endpackage

### src/cdse_if.sv
// Channel interfaces for the calendar date serial engine: request and result.
// Valid/ready handshake; a transaction moves at a clock edge with both high.
// Depends on cdse_pkg.
interface cdse_in_if import cdse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ACTION_W-1:0]       action;
	logic [YEAR_W-1:0]         in_year;
	logic [MONTH_W-1:0]        in_month;
	logic [DAY_W-1:0]          in_day;
	logic signed [DAYS_W-1:0]  days;

	modport source(output valid, action, in_year, in_month, in_day, days, input ready);
	modport sink(input valid, action, in_year, in_month, in_day, days, output ready);
endinterface

interface cdse_out_if import cdse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [YEAR_W-1:0]         out_year;
	logic [MONTH_W-1:0]        out_month;
	logic [DAY_W-1:0]          out_day;
	logic [SERIAL_W-1:0]       serial;
	logic signed [DIFF_W-1:0]  difference;
	logic                      error;

	modport source(output valid, out_year, out_month, out_day, serial, difference, error,
		input ready);
	modport sink(input valid, out_year, out_month, out_day, serial, difference, error,
		output ready);
endinterface

### src/calendar_date_serial_engine.sv
// Calendar date serial engine: stored Gregorian date, day serials, date arithmetic.
// One shared add/subtract unit walks years, then months, one step per cycle.
// Depends on cdse_pkg and the cdse_in_if / cdse_out_if interfaces.
//
//  channel  dir  interface    carries
//  cmd      in   cdse_in_if   action, in_year, in_month, in_day, days
//  rsp      out  cdse_out_if  out_year, out_month, out_day, serial, difference, error
//
// Sequence: a request that fails the range check or is an unused code goes from idle straight to
// the push state; any other walks Y years from BASE_YEAR (up to YEAR_SPAN-1), then M months (<= 11).
// The year walk through the shared adder is the longest part of a transaction.
// Reset: stored date is January 1 of BASE_YEAR, serial 1; no clearing pass.
// Stalls: the result sits in an output register; a finished transaction waits in the push
// state only while the previous result is still untaken. cmd.ready is high only when idle.
module calendar_date_serial_engine import cdse_pkg::*; #(
	parameter int BASE_YEAR = 1900,
	parameter int YEAR_SPAN = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	cdse_in_if.sink  cmd,
	cdse_out_if.source rsp
);

	localparam int N0   = BASE_YEAR - 1;
	localparam int N1   = BASE_YEAR + YEAR_SPAN - 1;
	localparam int TOP  = 365 * (N1 - N0) + N1 / 4 - N0 / 4 - N1 / 100 + N0 / 100
		+ N1 / 400 - N0 / 400;
	localparam int YW   = $clog2(YEAR_SPAN);
	localparam int SQW  = $clog2(TOP + 1);
	localparam int SERW = $clog2(TOP + 131073) + 1;
	localparam logic [1:0] B4   = 2'(BASE_YEAR % 4);
	localparam logic [6:0] B100 = 7'(BASE_YEAR % 100);
	localparam logic [8:0] B400 = 9'(BASE_YEAR % 400);

	state_t state_q, state_nxt;

	// stored date
	logic [YW-1:0]      year_q;
	logic [MONTH_W-1:0] month_q;
	logic [DAY_W-1:0]   day_q;
	logic [SQW-1:0]     serial_q;

	// walk registers
	logic                    to_serial_q;
	logic                    diff_mode_q;
	logic [YW-1:0]           ty_q;
	logic [MONTH_W-1:0]      tm_q;
	logic [DAY_W-1:0]        td_q;
	logic signed [SERW-1:0]  acc_q;
	logic signed [SERW-1:0]  tgt_q;
	logic [YW-1:0]           yoff_q;
	logic [1:0]              m4_q;
	logic [6:0]              m100_q;
	logic [8:0]              m400_q;
	logic [MONTH_W-1:0]      mm_q;
	logic                    err_q;
	logic signed [SERW-1:0]  diff_q;

	logic out_valid_q;
	logic [YEAR_W-1:0]        o_year_q;
	logic [MONTH_W-1:0]       o_month_q;
	logic [DAY_W-1:0]         o_day_q;
	logic [SERIAL_W-1:0]      o_serial_q;
	logic signed [DIFF_W-1:0] o_diff_q;
	logic                     o_err_q;

	// request decode
	action_t                  act;
	logic                     cmd_fire;
	logic [YEAR_W-1:0]        ny;
	logic [MONTH_W-1:0]       nm;
	logic [DAY_W-1:0]         nd;
	logic                     date_ok;
	logic                     walk_date;
	logic signed [SERW-1:0]   base;
	logic signed [SERW-1:0]   addend;
	logic signed [SERW-1:0]   tgt;
	logic                     tgt_ok;
	logic                     go_walk;

	// shared unit
	logic                     leap;
	logic [8:0]               ylen;
	logic [DAY_W-1:0]         mlen;
	logic signed [SERW-1:0]   len_ext;
	logic signed [SERW-1:0]   sum;
	logic                     year_step;
	logic                     month_step;
	logic                     day_ok;
	logic                     push_fire;

	assign act      = action_t'(cmd.action);
	assign cmd_fire = cmd.valid && cmd.ready;

	always_comb begin
		walk_date = (act == ACT_LOAD_DATE) || (act == ACT_DIFFERENCE);
		if (act == ACT_LOAD_DATE) begin
			ny = (cmd.in_year != '0) ? cmd.in_year : YEAR_W'(BASE_YEAR) + YEAR_W'(year_q);
			nm = (cmd.in_month != '0) ? cmd.in_month : month_q;
			nd = (cmd.in_day != '0) ? cmd.in_day : day_q;
		end else begin
			ny = cmd.in_year;
			nm = cmd.in_month;
			nd = cmd.in_day;
		end
		date_ok = ({1'b0, ny} >= 13'(BASE_YEAR)) && ({1'b0, ny} < 13'(BASE_YEAR + YEAR_SPAN))
			&& (nm >= 4'd1) && (nm <= 4'd12) && (nd != '0);
		base   = (act == ACT_LOAD_SERIAL) ? '0 : SERW'(serial_q);
		unique case (act)
			ACT_NEXT_DAY: addend = SERW'(1);
			ACT_PREV_DAY: addend = -SERW'(1);
			default:      addend = SERW'(cmd.days);
		endcase
		tgt     = base + addend;
		tgt_ok  = (tgt >= SERW'(1)) && (tgt <= SERW'(TOP));
		priority if (walk_date)
			go_walk = date_ok;
		else if (act == ACT_LOAD_SERIAL || act == ACT_NEXT_DAY || act == ACT_PREV_DAY
				|| act == ACT_ADD_DAYS)
			go_walk = tgt_ok;
		else
			go_walk = 1'b0;
	end

	always_comb begin
		leap    = (m100_q == '0) ? (m400_q == '0) : (m4_q == '0);
		ylen    = leap ? 9'd366 : 9'd365;
		mlen    = month_days(mm_q, leap);
		len_ext = (state_q == ST_YEAR) ? SERW'(ylen) : SERW'(mlen);
		sum     = to_serial_q ? acc_q + len_ext : acc_q - len_ext;
		year_step  = to_serial_q ? (yoff_q != ty_q) : (acc_q > len_ext);
		month_step = to_serial_q ? (mm_q != tm_q) : (acc_q > len_ext);
		day_ok     = td_q <= mlen;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire)
					state_nxt = go_walk ? ST_YEAR : ST_PUSH;
			end
			ST_YEAR: begin
				if (!year_step)
					state_nxt = ST_MONTH;
			end
			ST_MONTH: begin
				if (!month_step)
					state_nxt = ST_PUSH;
			end
			ST_PUSH: begin
				if (!out_valid_q || rsp.ready)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		push_fire = (state_q == ST_PUSH) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q   <= '0;
			month_q  <= 4'd1;
			day_q    <= 5'd1;
			serial_q <= SQW'(1);
		end else if (state_q == ST_MONTH && !month_step) begin
			if (!to_serial_q) begin
				year_q   <= yoff_q;
				month_q  <= mm_q;
				day_q    <= acc_q[DAY_W-1:0];
				serial_q <= tgt_q[SQW-1:0];
			end else if (day_ok && !diff_mode_q) begin
				year_q   <= ty_q;
				month_q  <= tm_q;
				day_q    <= td_q;
				serial_q <= acc_q[SQW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					err_q       <= ~go_walk && (act != ACT_LOAD_DATE || act == ACT_LOAD_DATE)
						&& (walk_date || act == ACT_LOAD_SERIAL || act == ACT_NEXT_DAY
						|| act == ACT_PREV_DAY || act == ACT_ADD_DAYS);
					diff_q      <= '0;
					to_serial_q <= walk_date;
					diff_mode_q <= (act == ACT_DIFFERENCE);
					ty_q        <= YW'(ny - YEAR_W'(BASE_YEAR));
					tm_q        <= nm;
					td_q        <= nd;
					acc_q       <= walk_date ? SERW'(nd) : tgt;
					tgt_q       <= tgt;
					yoff_q      <= '0;
					m4_q        <= B4;
					m100_q      <= B100;
					m400_q      <= B400;
					mm_q        <= 4'd1;
				end
			end
			ST_YEAR: begin
				if (year_step) begin
					acc_q  <= sum;
					yoff_q <= yoff_q + 1'b1;
					m4_q   <= m4_q + 1'b1;
					m100_q <= (m100_q == 7'd99) ? '0 : m100_q + 1'b1;
					m400_q <= (m400_q == 9'd399) ? '0 : m400_q + 1'b1;
				end
			end
			ST_MONTH: begin
				if (month_step) begin
					acc_q <= sum;
					mm_q  <= mm_q + 1'b1;
				end else if (to_serial_q) begin
					if (!day_ok)
						err_q <= 1'b1;
					else if (diff_mode_q)
						diff_q <= SERW'(serial_q) - acc_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push_fire)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			o_year_q   <= YEAR_W'(BASE_YEAR) + YEAR_W'(year_q);
			o_month_q  <= month_q;
			o_day_q    <= day_q;
			o_serial_q <= SERIAL_W'(serial_q);
			o_diff_q   <= diff_q[DIFF_W-1:0];
			o_err_q    <= err_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.out_year   = o_year_q;
	assign rsp.out_month  = o_month_q;
	assign rsp.out_day    = o_day_q;
	assign rsp.serial     = o_serial_q;
	assign rsp.difference = o_diff_q;
	assign rsp.error      = o_err_q;

	a_date_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		((YW + 1)'(year_q) < (YW + 1)'(YEAR_SPAN)) && (month_q >= 4'd1)
		&& (month_q <= 4'd12) && (day_q != '0))
		else $error("stored date left the span");

	a_serial_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(serial_q != '0) && ((SQW + 1)'(serial_q) <= (SQW + 1)'(TOP)))
		else $error("stored serial out of range");

	a_year_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR && to_serial_q) |-> (yoff_q <= ty_q))
		else $error("year walk passed its target");

	a_month_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (mm_q >= 4'd1) && (mm_q <= 4'd12))
		else $error("month walk out of range");

endmodule
